### rtl/hsb_slice_to_packed_rgb_defines.svh
// ----------------------------------------------------------------------------
// HSB slice to packed RGB: assertion macros
// Shared concurrent assertion forms. They sample on clk and are quiet in rst.
// ----------------------------------------------------------------------------
`ifndef HSB_SLICE_TO_PACKED_RGB_DEFINES_SVH
`define HSB_SLICE_TO_PACKED_RGB_DEFINES_SVH

// Same-cycle implication
`define HSB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hsb_slice_to_packed_rgb: same-cycle check failed");

// Next-cycle implication
`define HSB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hsb_slice_to_packed_rgb: next-cycle check failed");

`endif

### rtl/hsb_pkg.sv
// ----------------------------------------------------------------------------
// HSB slice package
// Shared constants, register indexes and the configuration bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package hsb_pkg;

  // Grid and fixed-point constants
  localparam logic [7:0]  GRID_LAST  = 8'd255;     // last grid row/column
  localparam logic [15:0] ONE_Q15    = 16'd32768;  // 1.0 in Q1.15
  localparam logic [15:0] HUE_MAX    = 16'd49151;  // largest hue below 6.0, Q3.13
  localparam logic [13:0] FRAC_ONE   = 14'd8192;   // 1.0 in Q.13
  localparam logic [28:0] PROD_ONE   = 29'h1000_0000; // 1.0 in Q.28
  localparam logic [15:0] RECIP_255  = 16'd32897;  // ceil(2^23 / 255)
  localparam int          RECIP_SHIFT = 23;

  // Configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_BRIGHT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BRIGHT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HUE_START  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HUE_STOP   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_LEVEL  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RED_POS    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_POS  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_POS   = 4'd7;

  // Configuration, already clamped to legal range
  typedef struct packed {
    logic [15:0] min_bright;
    logic [15:0] max_bright;
    logic [15:0] hue_start;
    logic [15:0] hue_stop;
    logic [15:0] sat_level;
    logic [4:0]  red_pos;
    logic [4:0]  green_pos;
    logic [4:0]  blue_pos;
  } hsb_cfg_t;

  // Saturate a 16-bit value at a ceiling
  function automatic logic [15:0] clamp16(input logic [15:0] v, input logic [15:0] hi);
    return (v > hi) ? hi : v;
  endfunction

endpackage

`default_nettype wire

### rtl/hsb_cfg_regs.sv
// ----------------------------------------------------------------------------
// HSB configuration registers
// Holds the range, saturation and byte position registers, clamped on write.
// ----------------------------------------------------------------------------
`default_nettype none

module hsb_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [hsb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data,
  output hsb_pkg::hsb_cfg_t             cfg
);
  import hsb_pkg::*;

  // Write one register per beat; saturate out-of-range values at write time
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_bright <= 16'd0;
      cfg.max_bright <= ONE_Q15;
      cfg.hue_start  <= 16'd0;
      cfg.hue_stop   <= HUE_MAX;
      cfg.sat_level  <= ONE_Q15;
      cfg.red_pos    <= 5'd16;
      cfg.green_pos  <= 5'd8;
      cfg.blue_pos   <= 5'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MIN_BRIGHT: cfg.min_bright <= clamp16(cfg_data, ONE_Q15);
        REG_MAX_BRIGHT: cfg.max_bright <= clamp16(cfg_data, ONE_Q15);
        REG_HUE_START:  cfg.hue_start  <= clamp16(cfg_data, HUE_MAX);
        REG_HUE_STOP:   cfg.hue_stop   <= clamp16(cfg_data, HUE_MAX);
        REG_SAT_LEVEL:  cfg.sat_level  <= clamp16(cfg_data, ONE_Q15);
        REG_RED_POS:    cfg.red_pos    <= cfg_data[4:0];
        REG_GREEN_POS:  cfg.green_pos  <= cfg_data[4:0];
        REG_BLUE_POS:   cfg.blue_pos   <= cfg_data[4:0];
        default: begin
          // unknown index: drop the beat
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/hsb_slice_to_packed_rgb.sv
// ----------------------------------------------------------------------------
// HSB slice to packed RGB
// Turns one brightness/hue grid point into a packed 32-bit RGB colour.
// ----------------------------------------------------------------------------
// Throughput is one pixel per clock unless out_stall backs up: a six-deep
// register pipeline (weights, reciprocal multiply for the hue divide by 255,
// quotient fix-up, saturation products, q/t products, sector select and pack)
// takes a new coordinate on every cycle that in_stall is low. Each stage holds
// its own valid bit and loads whenever it is empty or its successor moves, so
// out_stall only backs up stages that actually hold a pixel and bubbles are
// squeezed out. cfg_ready is always high; registers may only be written while
// no pixel is in flight.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hsb_slice_to_packed_rgb_defines.svh"

module hsb_slice_to_packed_rgb (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hsb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data,
  // coordinate input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    bright_index,
  input  logic [7:0]                    hue_index,
  // colour output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [31:0]                   packed_colour
);
  import hsb_pkg::*;

  localparam int NUM_STAGES = 5;  // stages before the output register

  // Hue sector codes
  localparam logic [2:0] SEC_0 = 3'd0;
  localparam logic [2:0] SEC_1 = 3'd1;
  localparam logic [2:0] SEC_2 = 3'd2;
  localparam logic [2:0] SEC_3 = 3'd3;
  localparam logic [2:0] SEC_4 = 3'd4;

  hsb_cfg_t cfg;

  // Configuration registers
  hsb_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign cfg_ready = 1'b1;

  // --------------------------------------------------------------------------
  // Pipeline flow control
  // --------------------------------------------------------------------------
  logic [NUM_STAGES:1]   vld;
  logic [NUM_STAGES+1:1] adv;

  // A stage loads when it is empty or its successor loads
  always_comb begin
    adv[NUM_STAGES+1] = !out_valid || !out_stall;
    for (int k = NUM_STAGES; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_stall = !adv[1];

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv[1]) begin
        vld[1] <= in_valid;
      end
      for (int k = 2; k <= NUM_STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
      if (adv[NUM_STAGES+1]) begin
        out_valid <= vld[NUM_STAGES];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: interpolate brightness and hue numerators
  // --------------------------------------------------------------------------
  logic [7:0]  bi_inv;
  logic [7:0]  hi_inv;
  logic [23:0] b_lo;
  logic [23:0] b_hi;
  logic [23:0] b_sum;
  logic [23:0] h_lo;
  logic [23:0] h_hi;
  logic [22:0] s1_b;
  logic [23:0] s1_hnum;

  always_comb begin
    bi_inv = GRID_LAST - bright_index;
    hi_inv = GRID_LAST - hue_index;
    b_lo   = {16'b0, bi_inv} * {8'b0, cfg.min_bright};
    b_hi   = {16'b0, bright_index} * {8'b0, cfg.max_bright};
    b_sum  = b_lo + b_hi;
    h_lo   = {16'b0, hi_inv} * {8'b0, cfg.hue_start};
    h_hi   = {16'b0, hue_index} * {8'b0, cfg.hue_stop};
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_b    <= b_sum[22:0];
      s1_hnum <= h_lo + h_hi;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: estimate hue / 255 by reciprocal multiply
  // --------------------------------------------------------------------------
  logic [39:0] hq_prod;
  logic [22:0] s2_b;
  logic [23:0] s2_hnum;
  logic [16:0] s2_hq;

  assign hq_prod = {16'b0, s1_hnum} * {24'b0, RECIP_255};

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_b    <= s1_b;
      s2_hnum <= s1_hnum;
      s2_hq   <= hq_prod[RECIP_SHIFT+16:RECIP_SHIFT];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: fix the estimate (it is at most one high), split hue
  // --------------------------------------------------------------------------
  logic [24:0] hq_x255;
  logic [16:0] hq_fix;
  logic [24:0] hfix_x255;
  logic [15:0] h_clamp;
  logic [22:0] s3_b;
  logic [2:0]  s3_sector;
  logic [12:0] s3_frac;

  always_comb begin
    hq_x255   = {8'b0, s2_hq} * {17'b0, GRID_LAST};
    hq_fix    = (hq_x255 > {1'b0, s2_hnum}) ? (s2_hq - 17'd1) : s2_hq;
    hfix_x255 = {8'b0, hq_fix} * {17'b0, GRID_LAST};
    h_clamp   = (hq_fix > {1'b0, HUE_MAX}) ? HUE_MAX : hq_fix[15:0];
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_b      <= s2_b;
      s3_sector <= h_clamp[15:13];
      s3_frac   <= h_clamp[12:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: saturation products and p
  // --------------------------------------------------------------------------
  logic [13:0] frac_inv;
  logic [15:0] sat_inv;
  logic [28:0] sf_prod;
  logic [29:0] st_prod;
  logic [38:0] p_prod;
  logic [22:0] s4_b;
  logic [2:0]  s4_sector;
  logic [7:0]  s4_v;
  logic [7:0]  s4_p;
  logic [28:0] s4_sf;
  logic [28:0] s4_st;

  always_comb begin
    frac_inv = FRAC_ONE - {1'b0, s3_frac};
    sat_inv  = ONE_Q15 - cfg.sat_level;
    sf_prod  = {13'b0, cfg.sat_level} * {16'b0, s3_frac};
    st_prod  = {14'b0, cfg.sat_level} * {16'b0, frac_inv};
    p_prod   = {16'b0, s3_b} * {23'b0, sat_inv};
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_b      <= s3_b;
      s4_sector <= s3_sector;
      s4_v      <= s3_b[22:15];
      s4_p      <= p_prod[37:30];
      s4_sf     <= sf_prod;
      s4_st     <= st_prod[28:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: q and t
  // --------------------------------------------------------------------------
  logic [28:0] q_fac;
  logic [28:0] t_fac;
  logic [51:0] q_prod;
  logic [51:0] t_prod;
  logic [2:0]  s5_sector;
  logic [7:0]  s5_v;
  logic [7:0]  s5_p;
  logic [7:0]  s5_q;
  logic [7:0]  s5_t;

  always_comb begin
    q_fac  = PROD_ONE - s4_sf;
    t_fac  = PROD_ONE - s4_st;
    q_prod = {29'b0, s4_b} * {23'b0, q_fac};
    t_prod = {29'b0, s4_b} * {23'b0, t_fac};
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_sector <= s4_sector;
      s5_v      <= s4_v;
      s5_p      <= s4_p;
      s5_q      <= q_prod[50:43];
      s5_t      <= t_prod[50:43];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: pick bytes by sector and pack
  // --------------------------------------------------------------------------
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [31:0] red_place;
  logic [31:0] green_place;
  logic [31:0] blue_place;

  always_comb begin
    unique case (s5_sector)
      SEC_0: begin
        red = s5_v; green = s5_t; blue = s5_p;
      end
      SEC_1: begin
        red = s5_q; green = s5_v; blue = s5_p;
      end
      SEC_2: begin
        red = s5_p; green = s5_v; blue = s5_t;
      end
      SEC_3: begin
        red = s5_p; green = s5_q; blue = s5_v;
      end
      SEC_4: begin
        red = s5_t; green = s5_p; blue = s5_v;
      end
      default: begin
        red = s5_v; green = s5_p; blue = s5_q;
      end
    endcase
    red_place   = {24'b0, red} << cfg.red_pos;
    green_place = {24'b0, green} << cfg.green_pos;
    blue_place  = {24'b0, blue} << cfg.blue_pos;
  end

  always_ff @(posedge clk) begin
    if (adv[NUM_STAGES+1]) begin
      packed_colour <= red_place | green_place | blue_place;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `HSB_ASSERT_NEXT(a_accept_lands, in_valid && !in_stall, vld[1])
  `HSB_ASSERT_NEXT(a_stall_holds, out_valid && out_stall && vld[NUM_STAGES], vld[NUM_STAGES])
  `HSB_ASSERT_NOW(a_hue_div_exact, vld[2], (hfix_x255 <= {1'b0, s2_hnum}) && (({1'b0, s2_hnum} - hfix_x255) < {17'b0, GRID_LAST}))
  `HSB_ASSERT_NOW(a_qt_fit_byte, vld[4], !q_prod[51] && !t_prod[51])

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HSB slice to packed RGB testbench
// Drives grid points into the converter under many register settings. These
// include downward ramps, out-of-range register values, high and overlapping
// byte positions, and random settings. Each packed colour is checked against
// a fixed-point prediction kept in step with the register writes.
// ----------------------------------------------------------------------------
module testbench;
  import hsb_pkg::*;

  localparam int HUE_FRAC_BITS  = 13;
  localparam longint unsigned COLOUR_FULL = 255;
  localparam int DRAIN_CYCLES   = 12;
  localparam int HOLD_AT        = 250;    // colour count that starts the long hold-off
  localparam int HOLD_CYCLES    = 120;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_PHASES  = 5;
  localparam int PHASE_POINTS   = 100;

  // Hue sectors, one per sixth of the wheel
  typedef enum logic [2:0] {
    SEC_RED, SEC_YELLOW, SEC_GREEN, SEC_CYAN, SEC_BLUE, SEC_MAGENTA
  } hue_sector_e;

  typedef struct packed {
    logic [7:0] row;
    logic [7:0] col;
  } grid_point_t;

  logic                 clk;
  logic                 rst          = 1'b1;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [15:0]          cfg_data     = '0;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic [7:0]           bright_index = '0;
  logic [7:0]           hue_index    = '0;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  logic [31:0]          packed_colour;

  hsb_cfg_t    cfg_model;
  grid_point_t pending_points[$];
  logic [31:0] expected_colours[$];
  grid_point_t next_point;
  logic [31:0] want_colour;
  bit          idle_on;
  bit          hold_done;
  int          gap_left;
  int          stall_left;
  int          idle_cycles;
  int          err_count;
  int          points_sent;
  int          colours_seen;
  int          settings_count;
  int          writes_count;

  hsb_slice_to_packed_rgb u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .bright_index  (bright_index),
    .hue_index     (hue_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .packed_colour (packed_colour)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Colour for one grid point under the current register settings
  function automatic logic [31:0] predict_colour(input logic [7:0] row, input logic [7:0] col);
    longint unsigned g1, bi, hi, mb, xb, s, hs, he, bscale, hq, f, v, p, q, t;
    hue_sector_e sector;
    logic [7:0] r, g, bl;
    g1 = GRID_LAST;
    bi = row;
    hi = col;
    mb = (cfg_model.min_bright > ONE_Q15) ? ONE_Q15 : cfg_model.min_bright;
    xb = (cfg_model.max_bright > ONE_Q15) ? ONE_Q15 : cfg_model.max_bright;
    s  = (cfg_model.sat_level > ONE_Q15) ? ONE_Q15 : cfg_model.sat_level;
    hs = (cfg_model.hue_start > HUE_MAX) ? HUE_MAX : cfg_model.hue_start;
    he = (cfg_model.hue_stop > HUE_MAX) ? HUE_MAX : cfg_model.hue_stop;
    // Interpolate brightness (scaled by 255) and hue along the grid
    bscale = (COLOUR_FULL * ((g1 - bi) * mb + bi * xb)) / g1;
    hq = ((g1 - hi) * hs + hi * he) / g1;
    if (hq > HUE_MAX) hq = HUE_MAX;
    sector = hue_sector_e'(hq >> HUE_FRAC_BITS);
    f = hq % FRAC_ONE;
    v = bscale >> 15;
    p = (bscale * (ONE_Q15 - s)) >> 30;
    q = (bscale * (PROD_ONE - s * f)) >> 43;
    t = (bscale * (PROD_ONE - s * (FRAC_ONE - f))) >> 43;
    case (sector)
      SEC_RED: begin
        r = v; g = t; bl = p;
      end
      SEC_YELLOW: begin
        r = q; g = v; bl = p;
      end
      SEC_GREEN: begin
        r = p; g = v; bl = t;
      end
      SEC_CYAN: begin
        r = p; g = q; bl = v;
      end
      SEC_BLUE: begin
        r = t; g = p; bl = v;
      end
      default: begin
        r = v; g = p; bl = q;
      end
    endcase
    return ({24'd0, r} << cfg_model.red_pos) | ({24'd0, g} << cfg_model.green_pos) |
           ({24'd0, bl} << cfg_model.blue_pos);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    $display("MISMATCH @%0t: %s: got %08h, want %08h", $time, what, got, want);
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int pick_stall();
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Brightness or saturation value: edges, any 16 bits, or in range
  function automatic logic [15:0] pick_q15();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return 16'd0;
    if (roll < 30) return ONE_Q15;
    if (roll < 40) return 16'($urandom);
    return 16'($urandom_range(0, ONE_Q15));
  endfunction

  function automatic logic [15:0] pick_hue();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return 16'd0;
    if (roll < 30) return HUE_MAX;
    if (roll < 40) return 16'($urandom);
    return 16'($urandom_range(0, HUE_MAX));
  endfunction

  function automatic logic [4:0] pick_pos();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 5'd0;
    if (roll == 1) return 5'd24;
    if (roll == 2) return 5'($urandom_range(25, 31));
    return 5'($urandom_range(0, 24));
  endfunction

  function automatic hsb_cfg_t random_setting();
    hsb_cfg_t c;
    c.min_bright = pick_q15();
    c.max_bright = pick_q15();
    c.hue_start  = pick_hue();
    c.hue_stop   = pick_hue();
    c.sat_level  = pick_q15();
    c.red_pos    = pick_pos();
    c.green_pos  = pick_pos();
    c.blue_pos   = pick_pos();
    return c;
  endfunction

  // One register beat; the local copy follows on the handshake
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    writes_count++;
    case (idx)
      REG_MIN_BRIGHT: cfg_model.min_bright = data;
      REG_MAX_BRIGHT: cfg_model.max_bright = data;
      REG_HUE_START:  cfg_model.hue_start  = data;
      REG_HUE_STOP:   cfg_model.hue_stop   = data;
      REG_SAT_LEVEL:  cfg_model.sat_level  = data;
      REG_RED_POS:    cfg_model.red_pos    = data[4:0];
      REG_GREEN_POS:  cfg_model.green_pos  = data[4:0];
      REG_BLUE_POS:   cfg_model.blue_pos   = data[4:0];
      default: ;
    endcase
  endtask

  // Write every register; position writes carry junk in the unused upper bits
  task automatic load_setting(input hsb_cfg_t c);
    write_reg(REG_MIN_BRIGHT, c.min_bright);
    write_reg(REG_MAX_BRIGHT, c.max_bright);
    write_reg(REG_HUE_START, c.hue_start);
    write_reg(REG_HUE_STOP, c.hue_stop);
    write_reg(REG_SAT_LEVEL, c.sat_level);
    write_reg(REG_RED_POS, {11'($urandom), c.red_pos});
    write_reg(REG_GREEN_POS, {11'($urandom), c.green_pos});
    write_reg(REG_BLUE_POS, {11'($urandom), c.blue_pos});
    settings_count++;
    @(negedge clk);
  endtask

  // Wait until no point is waiting or in flight, then let the pipeline empty
  task automatic drain_pipeline();
    while (pending_points.size() != 0 || in_valid || expected_colours.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic push_point(input logic [7:0] row, input logic [7:0] col);
    pending_points.push_back('{row: row, col: col});
  endtask

  task automatic push_corners();
    push_point(8'd0, 8'd0);
    push_point(8'd255, 8'd255);
    push_point(8'd0, 8'd255);
    push_point(8'd255, 8'd0);
  endtask

  // Drive grid points; a stalled beat holds until taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_colours.push_back(predict_colour(bright_index, hue_index));
        points_sent++;
        gap_left = idle_on ? pick_gap() : 0;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left == 0 && pending_points.size() != 0) begin
          next_point = pending_points.pop_front();
          in_valid     <= 1'b1;
          bright_index <= next_point.row;
          hue_index    <= next_point.col;
        end else begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end
      end
    end
  end

  // Check colours and drive the output stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_colours.size() == 0) begin
          report_mismatch("colour with no point pending", packed_colour, 32'd0);
        end else begin
          want_colour = expected_colours.pop_front();
          if (packed_colour !== want_colour)
            report_mismatch("packed_colour", packed_colour, want_colour);
        end
        colours_seen++;
        if (colours_seen == HOLD_AT) begin
          stall_left = HOLD_CYCLES;
          hold_done  = 1'b1;
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 99) < 20) begin
        out_stall <= 1'b1;
        stall_left = pick_stall() - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // End the run if no beat moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    hsb_cfg_t setting;
    cfg_model = '{min_bright: 16'd0, max_bright: ONE_Q15, hue_start: 16'd0,
                  hue_stop: HUE_MAX, sat_level: ONE_Q15, red_pos: 5'd16,
                  green_pos: 5'd8, blue_pos: 5'd0};
    idle_on = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset setting: corners and one point in every hue sector
    push_corners();
    push_point(8'd255, 8'd43);
    push_point(8'd170, 8'd85);
    push_point(8'd255, 8'd86);
    push_point(8'd128, 8'd128);
    push_point(8'd200, 8'd171);
    push_point(8'd255, 8'd213);
    drain_pipeline();

    // Downward ramps, no saturation, red and blue swapped
    load_setting('{min_bright: ONE_Q15, max_bright: 16'd0, hue_start: HUE_MAX,
                   hue_stop: 16'd0, sat_level: 16'd0, red_pos: 5'd0,
                   green_pos: 5'd8, blue_pos: 5'd16});
    push_corners();
    drain_pipeline();

    // Every register above its range; positions past the top byte
    load_setting('{min_bright: 16'hffff, max_bright: 16'hffff, hue_start: 16'hffff,
                   hue_stop: 16'hffff, sat_level: 16'hffff, red_pos: 5'd31,
                   green_pos: 5'd30, blue_pos: 5'd25});
    push_corners();
    drain_pipeline();

    // All bytes at one position, full ramps
    load_setting('{min_bright: 16'd0, max_bright: ONE_Q15, hue_start: 16'd0,
                   hue_stop: HUE_MAX, sat_level: ONE_Q15, red_pos: 5'd24,
                   green_pos: 5'd24, blue_pos: 5'd24});
    push_corners();
    drain_pipeline();

    // Black at any hue, all bytes at the bottom
    load_setting('{min_bright: 16'd0, max_bright: 16'd0, hue_start: 16'd1,
                   hue_stop: 16'd49150, sat_level: 16'd16384, red_pos: 5'd0,
                   green_pos: 5'd0, blue_pos: 5'd0});
    push_corners();
    drain_pipeline();

    // Random settings, random points; the first phase runs without idling
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      setting = random_setting();
      load_setting(setting);
      idle_on = (ph != 0);
      for (int n = 0; n < PHASE_POINTS; n++) begin
        case ($urandom_range(0, 9))
          0: push_point($urandom_range(0, 1) ? 8'd255 : 8'd0, 8'($urandom));
          1: push_point(8'($urandom), $urandom_range(0, 1) ? 8'd255 : 8'd0);
          default: push_point(8'($urandom), 8'($urandom));
        endcase
      end
      drain_pipeline();
    end

    idle_on = 1'b1;
    repeat (20) @(negedge clk);
    $display("Checked %0d colours from %0d points over %0d register settings (%0d writes).",
             colours_seen, points_sent, settings_count, writes_count);
    $display("Long output hold-off %0s; %0d mismatches.",
             hold_done ? "exercised" : "not reached", err_count);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/hsb_pkg.sv
rtl/hsb_cfg_regs.sv
rtl/hsb_slice_to_packed_rgb.sv
tb/testbench.sv
